FILE: rtl/roulette_select_crossover_unit_assert.svh
// Assertion macros shared by the roulette select crossover unit checkers
`ifndef ROULETTE_SELECT_CROSSOVER_UNIT_ASSERT_SVH
`define ROULETTE_SELECT_CROSSOVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define RSCU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rscu assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RSCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rscu assertion failed");

`endif

FILE: rtl/rscu_pkg.sv
// Shared constants, state encoding and control/status types for the roulette crossover unit
package rscu_pkg;

  // Population and field sizes
  localparam int MAX_POP    = 64;
  localparam int SLOT_W     = $clog2(MAX_POP);
  localparam int GENOME_W   = 36;
  localparam int FIT_W      = 17;
  localparam int DRAW_W     = 16;
  localparam int TOTAL_W    = FIT_W + SLOT_W;
  localparam int POP_W      = 7;
  localparam int RATE_W     = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int POINT_W    = $clog2(GENOME_W);

  localparam logic [FIT_W-1:0]  FIX_ONE    = FIT_W'(65536);
  localparam logic [POP_W-1:0]  POP_RESET  = POP_W'(32);
  localparam logic [POP_W-1:0]  POP_MAX    = POP_W'(MAX_POP);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(45875);

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_BREED = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 1'b1;

  // Controller states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_WR_RD    = 10'b00_0000_0010,
    ST_WR_UPD   = 10'b00_0000_0100,
    ST_SLICE    = 10'b00_0000_1000,
    ST_WALK_RD  = 10'b00_0001_0000,
    ST_WALK_CMP = 10'b00_0010_0000,
    ST_GA_RD    = 10'b00_0100_0000,
    ST_GB_RD    = 10'b00_1000_0000,
    ST_CROSS    = 10'b01_0000_0000,
    ST_OUTPUT   = 10'b10_0000_0000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted transaction
    logic wr_rd;       // read old entry of the written slot
    logic wr_commit;   // write slot, update fitness total
    logic slice_load;  // compute slice, restart walk
    logic walk_rd;     // read fitness at walk index
    logic walk_cmp;    // accumulate and test
    logic ga_rd;       // read first parent genome
    logic gb_rd;       // read second parent genome
    logic xover;       // form the children
    logic out_load;    // load the output register
    logic second;      // working on second selection
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pick_done;   // walk found its slot this cycle
  } status_t;

endpackage

FILE: rtl/rscu_ctrl.sv
// Controller state machine sequencing slot writes and breed transactions
module rscu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_cmd,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  rscu_pkg::status_t st,
  output rscu_pkg::ctrl_t   ctl
);

  rscu_pkg::state_t state_r, state_nxt;
  logic             second_r, second_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r;
    ctl           = '0;
    ctl.second    = second_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      rscu_pkg::ST_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          second_nxt = 1'b0;
          state_nxt  = (in_cmd == rscu_pkg::CMD_BREED) ? rscu_pkg::ST_SLICE
                                                       : rscu_pkg::ST_WR_RD;
        end
      end
      rscu_pkg::ST_WR_RD: begin
        ctl.wr_rd = 1'b1;
        state_nxt = rscu_pkg::ST_WR_UPD;
      end
      rscu_pkg::ST_WR_UPD: begin
        ctl.wr_commit = 1'b1;
        state_nxt     = rscu_pkg::ST_OUTPUT;
      end
      rscu_pkg::ST_SLICE: begin
        ctl.slice_load = 1'b1;
        state_nxt      = rscu_pkg::ST_WALK_RD;
      end
      rscu_pkg::ST_WALK_RD: begin
        ctl.walk_rd = 1'b1;
        state_nxt   = rscu_pkg::ST_WALK_CMP;
      end
      rscu_pkg::ST_WALK_CMP: begin
        ctl.walk_cmp = 1'b1;
        if (st.pick_done) begin
          if (second_r) begin
            state_nxt = rscu_pkg::ST_GA_RD;
          end else begin
            second_nxt = 1'b1;
            state_nxt  = rscu_pkg::ST_SLICE;
          end
        end else begin
          state_nxt = rscu_pkg::ST_WALK_RD;
        end
      end
      rscu_pkg::ST_GA_RD: begin
        ctl.ga_rd = 1'b1;
        state_nxt = rscu_pkg::ST_GB_RD;
      end
      rscu_pkg::ST_GB_RD: begin
        ctl.gb_rd = 1'b1;
        state_nxt = rscu_pkg::ST_CROSS;
      end
      rscu_pkg::ST_CROSS: begin
        ctl.xover = 1'b1;
        state_nxt = rscu_pkg::ST_OUTPUT;
      end
      rscu_pkg::ST_OUTPUT: begin
        // hand over when the output register is free or being taken
        if (!out_valid_r || !out_stall) begin
          ctl.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rscu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rscu_pkg::ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rscu_pkg::ST_IDLE;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != rscu_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/rscu_datapath.sv
// Datapath: population stores, fitness total, roulette walk, crossover and output register
module rscu_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rscu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rscu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_cmd,
  input  logic [rscu_pkg::SLOT_W-1:0]         in_slot,
  input  logic [rscu_pkg::GENOME_W-1:0]       in_genome,
  input  logic [rscu_pkg::FIT_W-1:0]          in_fitness_value,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_first,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_second,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_cross,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_point,
  output logic [rscu_pkg::GENOME_W-1:0]       out_child_first,
  output logic [rscu_pkg::GENOME_W-1:0]       out_child_second,
  output logic [rscu_pkg::SLOT_W-1:0]         out_parent_first,
  output logic [rscu_pkg::SLOT_W-1:0]         out_parent_second,
  input  rscu_pkg::ctrl_t                     ctl,
  output rscu_pkg::status_t                   st
);

  localparam int PTPROD_W = rscu_pkg::DRAW_W + rscu_pkg::POINT_W + 1;
  localparam int SLPROD_W = rscu_pkg::DRAW_W + rscu_pkg::TOTAL_W;
  localparam logic [rscu_pkg::GENOME_W-1:0] GMASK = '1;

  // Configuration registers
  logic [rscu_pkg::POP_W-1:0]  pop_r;
  logic [rscu_pkg::RATE_W-1:0] rate_r;

  // Latched transaction
  logic                           cmd_r;
  logic [rscu_pkg::SLOT_W-1:0]    slot_r;
  logic [rscu_pkg::GENOME_W-1:0]  genome_r;
  logic [rscu_pkg::FIT_W-1:0]     fit_r;
  logic [rscu_pkg::DRAW_W-1:0]    draw1_r;
  logic [rscu_pkg::DRAW_W-1:0]    draw2_r;
  logic [rscu_pkg::POINT_W-1:0]   point_r;
  logic                           cross_r;

  // Stores and read port
  logic [rscu_pkg::FIT_W-1:0]     fit_mem [rscu_pkg::MAX_POP];
  logic [rscu_pkg::GENOME_W-1:0]  gen_mem [rscu_pkg::MAX_POP];
  logic [rscu_pkg::MAX_POP-1:0]   vld_r;
  logic [rscu_pkg::SLOT_W-1:0]    rd_addr;
  logic [rscu_pkg::FIT_W-1:0]     fit_q_r;
  logic [rscu_pkg::GENOME_W-1:0]  gen_q_r;
  logic                           vld_q_r;
  logic [rscu_pkg::FIT_W-1:0]     fit_eff;
  logic [rscu_pkg::GENOME_W-1:0]  gen_eff;

  // Walk and result registers
  logic [rscu_pkg::TOTAL_W-1:0]   total_r;
  logic [rscu_pkg::TOTAL_W-1:0]   slice_r;
  logic [rscu_pkg::TOTAL_W-1:0]   sum_r;
  logic [rscu_pkg::TOTAL_W-1:0]   sum_add;
  logic [rscu_pkg::SLOT_W-1:0]    idx_r;
  logic [rscu_pkg::SLOT_W-1:0]    last_idx;
  logic [rscu_pkg::POP_W-1:0]     pop_m1;
  logic [rscu_pkg::SLOT_W-1:0]    pa_r;
  logic [rscu_pkg::SLOT_W-1:0]    pb_r;
  logic [rscu_pkg::GENOME_W-1:0]  ga_r;
  logic [rscu_pkg::GENOME_W-1:0]  ca_r;
  logic [rscu_pkg::GENOME_W-1:0]  cb_r;
  logic [rscu_pkg::GENOME_W-1:0]  tail_mask;
  logic [rscu_pkg::GENOME_W-1:0]  head_mask;
  logic [rscu_pkg::FIT_W-1:0]     fit_sat;
  logic [PTPROD_W-1:0]            point_prod;
  logic [SLPROD_W-1:0]            slice_prod;
  logic [rscu_pkg::DRAW_W-1:0]    draw_sel;
  logic                           hit;
  logic [rscu_pkg::GENOME_W-1:0]  out_cf_r, out_cs_r;
  logic [rscu_pkg::SLOT_W-1:0]    out_pf_r, out_ps_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r  <= rscu_pkg::POP_RESET;
      rate_r <= rscu_pkg::RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rscu_pkg::CFG_POP:  pop_r  <= cfg_wdata[rscu_pkg::POP_W-1:0];
        rscu_pkg::CFG_RATE: rate_r <= cfg_wdata[rscu_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Last slot in use: zero acts as one, large values clamp to the store depth
  assign pop_m1 = pop_r - rscu_pkg::POP_W'(1);
  always_comb begin
    if (pop_r == '0) begin
      last_idx = '0;
    end else if (pop_r > rscu_pkg::POP_MAX) begin
      last_idx = rscu_pkg::SLOT_W'(rscu_pkg::MAX_POP - 1);
    end else begin
      last_idx = pop_m1[rscu_pkg::SLOT_W-1:0];
    end
  end

  // Transaction capture: saturate fitness, scale crossover point, decide crossover
  assign fit_sat    = (in_fitness_value > rscu_pkg::FIX_ONE) ? rscu_pkg::FIX_ONE
                                                             : in_fitness_value;
  assign point_prod = PTPROD_W'(in_draw_point) * PTPROD_W'(rscu_pkg::GENOME_W);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_cmd;
      slot_r   <= in_slot;
      genome_r <= in_genome;
      fit_r    <= fit_sat;
      draw1_r  <= in_draw_first;
      draw2_r  <= in_draw_second;
      point_r  <= point_prod[rscu_pkg::DRAW_W +: rscu_pkg::POINT_W];
      cross_r  <= (rscu_pkg::RATE_W'(in_draw_cross) < rate_r);
    end
  end

  // Read address select
  always_comb begin
    if (ctl.wr_rd) begin
      rd_addr = slot_r;
    end else if (ctl.ga_rd) begin
      rd_addr = pa_r;
    end else if (ctl.gb_rd) begin
      rd_addr = pb_r;
    end else begin
      rd_addr = idx_r;
    end
  end

  // Population stores, registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_commit) begin
      fit_mem[slot_r] <= fit_r;
      gen_mem[slot_r] <= genome_r;
    end
    fit_q_r <= fit_mem[rd_addr];
    gen_q_r <= gen_mem[rd_addr];
    vld_q_r <= vld_r[rd_addr];
  end

  // Entry valid bits: unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_commit) begin
      vld_r[slot_r] <= 1'b1;
    end
  end

  assign fit_eff = vld_q_r ? fit_q_r : '0;
  assign gen_eff = vld_q_r ? gen_q_r : '0;

  // Running fitness total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctl.wr_commit) begin
      total_r <= total_r - rscu_pkg::TOTAL_W'(fit_eff) + rscu_pkg::TOTAL_W'(fit_r);
    end
  end

  // Slice = draw * total >> 16
  assign draw_sel   = ctl.second ? draw2_r : draw1_r;
  assign slice_prod = SLPROD_W'(draw_sel) * SLPROD_W'(total_r);

  // Roulette walk compare
  assign sum_add      = sum_r + rscu_pkg::TOTAL_W'(fit_eff);
  assign hit          = (sum_add >= slice_r) || (idx_r == last_idx);
  assign st.pick_done = hit;

  always_ff @(posedge clk) begin
    if (ctl.slice_load) begin
      slice_r <= slice_prod[rscu_pkg::DRAW_W +: rscu_pkg::TOTAL_W];
      sum_r   <= '0;
      idx_r   <= '0;
    end else if (ctl.walk_cmp) begin
      if (hit) begin
        if (ctl.second) begin
          pb_r <= idx_r;
        end else begin
          pa_r <= idx_r;
        end
      end else begin
        sum_r <= sum_add;
        idx_r <= idx_r + rscu_pkg::SLOT_W'(1);
      end
    end
  end

  // Single point crossover, point counted from the MSB
  assign tail_mask = GMASK >> point_r;
  assign head_mask = ~tail_mask;

  always_ff @(posedge clk) begin
    if (ctl.gb_rd) begin
      ga_r <= gen_eff;
    end
    if (ctl.xover) begin
      if (cross_r) begin
        ca_r <= (ga_r & head_mask) | (gen_eff & tail_mask);
        cb_r <= (gen_eff & head_mask) | (ga_r & tail_mask);
      end else begin
        ca_r <= ga_r;
        cb_r <= gen_eff;
      end
    end
  end

  // Output register; write transactions return zeros
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (cmd_r == rscu_pkg::CMD_WRITE) begin
        out_cf_r <= '0;
        out_cs_r <= '0;
        out_pf_r <= '0;
        out_ps_r <= '0;
      end else begin
        out_cf_r <= ca_r;
        out_cs_r <= cb_r;
        out_pf_r <= pa_r;
        out_ps_r <= pb_r;
      end
    end
  end

  assign out_child_first   = out_cf_r;
  assign out_child_second  = out_cs_r;
  assign out_parent_first  = out_pf_r;
  assign out_parent_second = out_ps_r;

endmodule

FILE: rtl/roulette_select_crossover_unit.sv
// Top level of the roulette-wheel selection and single-point crossover unit
// Holds a 64-slot population (36-bit genomes, Q1.16 fitness) and a running
// fitness total; fitness and genome stores read as zero after reset until a
// slot is written, with no clearing pass. A write transaction (cmd 0) reads
// the old entry of the slot, then writes the slot and updates the total,
// then loads the output register. A breed transaction (cmd 1) runs two
// roulette walks, each visiting 1 up to population_size slots and reading
// one fitness entry at a time through the single store read port, then
// reads both parent genomes, forms the children and loads the output
// register. The unit goes back to idle after that load before it accepts
// the next transaction, and the load itself waits while an earlier result
// is still stalled in the output register. One transaction is worked at a
// time; a new one is accepted while the previous result waits in the
// output register. Write configuration only while no transaction is in
// flight.
module roulette_select_crossover_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rscu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rscu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [rscu_pkg::SLOT_W-1:0]         in_slot,
  input  logic [rscu_pkg::GENOME_W-1:0]       in_genome,
  input  logic [rscu_pkg::FIT_W-1:0]          in_fitness_value,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_first,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_second,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_cross,
  input  logic [rscu_pkg::DRAW_W-1:0]         in_draw_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rscu_pkg::GENOME_W-1:0]       out_child_first,
  output logic [rscu_pkg::GENOME_W-1:0]       out_child_second,
  output logic [rscu_pkg::SLOT_W-1:0]         out_parent_first,
  output logic [rscu_pkg::SLOT_W-1:0]         out_parent_second
);

  rscu_pkg::ctrl_t   ctl;
  rscu_pkg::status_t st;

  // Sequencer
  rscu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  // Stores, arithmetic and output register
  rscu_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_slot           (in_slot),
    .in_genome         (in_genome),
    .in_fitness_value  (in_fitness_value),
    .in_draw_first     (in_draw_first),
    .in_draw_second    (in_draw_second),
    .in_draw_cross     (in_draw_cross),
    .in_draw_point     (in_draw_point),
    .out_child_first   (out_child_first),
    .out_child_second  (out_child_second),
    .out_parent_first  (out_parent_first),
    .out_parent_second (out_parent_second),
    .ctl               (ctl),
    .st                (st)
  );

endmodule

FILE: rtl/rscu_checker.sv
// Port-level checker for the roulette select crossover unit, bound to the top level
`include "roulette_select_crossover_unit_assert.svh"

module rscu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rscu_pkg::GENOME_W-1:0] out_child_first,
  input logic [rscu_pkg::GENOME_W-1:0] out_child_second,
  input logic [rscu_pkg::SLOT_W-1:0]   out_parent_first,
  input logic [rscu_pkg::SLOT_W-1:0]   out_parent_second
);

  // only one transaction in work at a time
  `RSCU_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `RSCU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_child_first) && $stable(out_parent_first))

  // same parent twice gives identical children, crossover or not
  `RSCU_ASSERT_IMPL(a_same_parent, clk, rst_n, out_valid && (out_parent_first == out_parent_second), out_child_first == out_child_second)

endmodule

bind roulette_select_crossover_unit rscu_checker u_rscu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_child_first   (out_child_first),
  .out_child_second  (out_child_second),
  .out_parent_first  (out_parent_first),
  .out_parent_second (out_parent_second)
);

FILE: tb/sv/roulette_select_crossover_checker.sv
// Offspring checker: predicts each transaction of the roulette crossover unit and compares results
module roulette_select_crossover_checker
  import rscu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [GENOME_W-1:0]   in_genome,
  input  logic [FIT_W-1:0]      in_fitness_value,
  input  logic [DRAW_W-1:0]     in_draw_first,
  input  logic [DRAW_W-1:0]     in_draw_second,
  input  logic [DRAW_W-1:0]     in_draw_cross,
  input  logic [DRAW_W-1:0]     in_draw_point,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [GENOME_W-1:0]   out_child_first,
  input  logic [GENOME_W-1:0]   out_child_second,
  input  logic [SLOT_W-1:0]     out_parent_first,
  input  logic [SLOT_W-1:0]     out_parent_second,
  output int                    fail_count,
  output int                    backlog,
  output int                    results_seen,
  output int                    crossings
);

  typedef struct packed {
    logic [GENOME_W-1:0] child_first;
    logic [GENOME_W-1:0] child_second;
    logic [SLOT_W-1:0]   parent_first;
    logic [SLOT_W-1:0]   parent_second;
  } offspring_t;

  // Shadow copy of the population and the registers
  logic [GENOME_W-1:0] genome_copy [MAX_POP];
  logic [FIT_W-1:0]    fit_copy [MAX_POP];
  logic [TOTAL_W-1:0]  fit_total;
  logic [POP_W-1:0]    pop_copy;
  logic [RATE_W-1:0]   rate_copy;

  offspring_t offspring_q [$];
  offspring_t want;

  // Roulette walk over the slots in use; falls back to the last one in use
  function automatic logic [SLOT_W-1:0] spin_wheel(input logic [DRAW_W-1:0] draw);
    logic [DRAW_W+TOTAL_W-1:0] slice;
    logic [TOTAL_W:0]          prefix;
    logic [SLOT_W-1:0]         pick;
    int                        span;
    int                        i;
    bit                        hit;
    if (pop_copy == '0) begin
      span = 1;
    end else if (pop_copy > POP_MAX) begin
      span = MAX_POP;
    end else begin
      span = int'(pop_copy);
    end
    slice  = ((DRAW_W+TOTAL_W)'(draw) * (DRAW_W+TOTAL_W)'(fit_total)) >> DRAW_W;
    prefix = '0;
    hit    = 1'b0;
    pick   = SLOT_W'(span - 1);
    for (i = 0; i < span; i++) begin
      prefix += fit_copy[i];
      if (!hit && prefix >= slice) begin
        pick = SLOT_W'(i);
        hit  = 1'b1;
      end
    end
    return pick;
  endfunction

  // Applies one transaction to the shadow population and returns its result
  function automatic offspring_t forecast_offspring(
    input logic                cmd,
    input logic [SLOT_W-1:0]   slot,
    input logic [GENOME_W-1:0] genome,
    input logic [FIT_W-1:0]    fit,
    input logic [DRAW_W-1:0]   draw_a,
    input logic [DRAW_W-1:0]   draw_b,
    input logic [DRAW_W-1:0]   draw_x,
    input logic [DRAW_W-1:0]   draw_p
  );
    offspring_t          res;
    logic [FIT_W-1:0]    kept;
    logic [GENOME_W-1:0] ga;
    logic [GENOME_W-1:0] gb;
    logic [GENOME_W-1:0] tail;
    logic [GENOME_W:0]   tail_wide;
    int unsigned         point;
    res = '0;
    if (cmd == CMD_WRITE) begin
      // fitness saturates at 1.0; total tracks the exact sum
      kept      = (fit > FIX_ONE) ? FIX_ONE : fit;
      fit_total = fit_total - TOTAL_W'(fit_copy[slot]) + TOTAL_W'(kept);
      fit_copy[slot]    = kept;
      genome_copy[slot] = genome;
    end else begin
      res.parent_first  = spin_wheel(draw_a);
      res.parent_second = spin_wheel(draw_b);
      ga = genome_copy[res.parent_first];
      gb = genome_copy[res.parent_second];
      res.child_first  = ga;
      res.child_second = gb;
      if ({1'b0, draw_x} < rate_copy) begin
        // head counted from the MSB; point zero swaps everything
        point     = (int'(draw_p) * GENOME_W) >> DRAW_W;
        tail_wide = ((GENOME_W+1)'(1) << (GENOME_W - point)) - (GENOME_W+1)'(1);
        tail      = tail_wide[GENOME_W-1:0];
        res.child_first  = (ga & ~tail) | (gb & tail);
        res.child_second = (gb & ~tail) | (ga & tail);
        crossings++;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_v, got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", field, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Monitor: register writes, result transactions, then input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (genome_copy[i]) begin
        genome_copy[i] = '0;
        fit_copy[i]    = '0;
      end
      fit_total    = '0;
      pop_copy     = POP_RESET;
      rate_copy    = RATE_RESET;
      offspring_q.delete();
      fail_count   = 0;
      results_seen = 0;
      crossings    = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POP) begin
          pop_copy = cfg_wdata[POP_W-1:0];
        end else if (cfg_index == CFG_RATE) begin
          rate_copy = cfg_wdata[RATE_W-1:0];
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (offspring_q.size() == 0) begin
          $error("result transaction with nothing outstanding");
          fail_count++;
        end else begin
          want = offspring_q.pop_front();
          check_field("child_first", 64'(want.child_first), 64'(out_child_first));
          check_field("child_second", 64'(want.child_second), 64'(out_child_second));
          check_field("parent_first", 64'(want.parent_first), 64'(out_parent_first));
          check_field("parent_second", 64'(want.parent_second), 64'(out_parent_second));
        end
      end
      if (in_valid && !in_stall) begin
        offspring_q.push_back(forecast_offspring(in_cmd, in_slot, in_genome,
          in_fitness_value, in_draw_first, in_draw_second, in_draw_cross, in_draw_point));
      end
    end
    backlog <= offspring_q.size();
  end

endmodule

FILE: tb/sv/roulette_select_crossover_unit_tb.sv
// Testbench top for the roulette crossover unit: stimulus, flow control and verdict
module roulette_select_crossover_unit_tb;
  import rscu_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 800;
  localparam int PHASES       = 7;

  typedef struct packed {
    logic                cmd;
    logic [SLOT_W-1:0]   slot;
    logic [GENOME_W-1:0] genome;
    logic [FIT_W-1:0]    fitness;
    logic [DRAW_W-1:0]   draw_first;
    logic [DRAW_W-1:0]   draw_second;
    logic [DRAW_W-1:0]   draw_cross;
    logic [DRAW_W-1:0]   draw_point;
  } request_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [SLOT_W-1:0]     in_slot;
  logic [GENOME_W-1:0]   in_genome;
  logic [FIT_W-1:0]      in_fitness_value;
  logic [DRAW_W-1:0]     in_draw_first;
  logic [DRAW_W-1:0]     in_draw_second;
  logic [DRAW_W-1:0]     in_draw_cross;
  logic [DRAW_W-1:0]     in_draw_point;
  logic                  out_valid;
  logic                  out_stall;
  logic [GENOME_W-1:0]   out_child_first;
  logic [GENOME_W-1:0]   out_child_second;
  logic [SLOT_W-1:0]     out_parent_first;
  logic [SLOT_W-1:0]     out_parent_second;

  int fail_count;
  int backlog;
  int results_seen;
  int crossings;
  int cycles = 0;
  int sent;
  int breeds_sent;
  int eff_pop;
  int hold_asks;
  bit quiet;

  roulette_select_crossover_unit dut (.*);

  roulette_select_crossover_checker offspring_check (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    int served;
    served    = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != served) begin
        served = hold_asks;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Presents one transaction, with an optional idle burst ahead of it
  task automatic offer(input request_t req);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= req.cmd;
    in_slot          <= req.slot;
    in_genome        <= req.genome;
    in_fitness_value <= req.fitness;
    in_draw_first    <= req.draw_first;
    in_draw_second   <= req.draw_second;
    in_draw_cross    <= req.draw_cross;
    in_draw_point    <= req.draw_point;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (req.cmd == CMD_BREED) breeds_sent++;
  endtask

  function automatic request_t write_req(input int slot, input logic [GENOME_W-1:0] genome,
                                         input int fit);
    request_t req;
    req         = '0;
    req.cmd     = CMD_WRITE;
    req.slot    = SLOT_W'(slot);
    req.genome  = genome;
    req.fitness = FIT_W'(fit);
    return req;
  endfunction

  function automatic request_t breed_req(input int da, db, dx, dp);
    request_t req;
    req             = '0;
    req.cmd         = CMD_BREED;
    req.draw_first  = DRAW_W'(da);
    req.draw_second = DRAW_W'(db);
    req.draw_cross  = DRAW_W'(dx);
    req.draw_point  = DRAW_W'(dp);
    return req;
  endfunction

  // Draws lean toward both ends of the wheel
  function automatic logic [DRAW_W-1:0] pick_draw();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return DRAW_W'($urandom_range(0, 65535));
  endfunction

  function automatic request_t random_request(input int write_pct);
    request_t    req;
    logic [63:0] wide;
    int          roll;
    wide = {$urandom(), $urandom()};
    req.cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_BREED;
    // mostly slots the walk covers, some beyond it to skew the total
    if ($urandom_range(0, 3) == 0) begin
      req.slot = SLOT_W'($urandom_range(0, MAX_POP - 1));
    end else begin
      req.slot = SLOT_W'($urandom_range(0, eff_pop - 1));
    end
    req.genome = wide[GENOME_W-1:0];
    roll = $urandom_range(0, 9);
    case (roll)
      0: req.fitness = '0;
      1: req.fitness = FIX_ONE;
      2: req.fitness = FIT_W'($urandom_range(65537, 131071));
      3: req.fitness = FIT_W'($urandom_range(0, 255));
      default: req.fitness = FIT_W'($urandom_range(0, 65536));
    endcase
    req.draw_first  = pick_draw();
    req.draw_second = pick_draw();
    req.draw_cross  = pick_draw();
    req.draw_point  = pick_draw();
    return req;
  endfunction

  // Drops valid and waits until every outstanding result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned pop, input int unsigned rate);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POP;
    cfg_wdata <= CFG_DATA_W'(pop);
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_wdata <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    eff_pop = (pop == 0) ? 1 : ((pop > MAX_POP) ? MAX_POP : int'(pop));
  endtask

  // Stimulus
  initial begin
    int          phase;
    int          items;
    int          write_pct;
    int unsigned pop;
    int unsigned rate;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_POP;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_cmd           = CMD_WRITE;
    in_slot          = '0;
    in_genome        = '0;
    in_fitness_value = '0;
    in_draw_first    = '0;
    in_draw_second   = '0;
    in_draw_cross    = '0;
    in_draw_point    = '0;
    quiet            = 1'b0;
    hold_asks        = 0;
    sent             = 0;
    breeds_sent      = 0;
    eff_pop          = int'(POP_RESET);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings
    // empty population: zero total, slice zero everywhere
    offer(breed_req(0, 0, 0, 0));
    offer(breed_req(65535, 65535, 65535, 65535));
    offer(write_req(0, '1, 65536));
    // saturating fitness in a slot outside the walk
    offer(write_req(63, '0, 131071));
    offer(write_req(31, 36'hA_AAAA_AAAA, 1));
    offer(write_req(10, 36'h5_5555_5555, 12345));
    // slice beyond every slot in use falls back to the last one
    offer(breed_req(0, 65535, 0, 0));
    offer(breed_req(65535, 0, 45874, 65535));
    // draw equal to the rate: no crossover
    offer(breed_req(32768, 20000, 45875, 30000));
    // first point past zero
    offer(breed_req(40000, 12000, 10, 1821));
    offer(breed_req(50000, 100, 10, 1820));
    // overwrite lowers the total
    offer(write_req(0, 36'h0_F0F0_F0F0, 0));
    offer(breed_req(65535, 30000, 100, 32768));
    offer(write_req(1, 36'h8_0000_0001, 65535));
    offer(breed_req(1, 65534, 0, 65535));
    offer(write_req(31, '0, 0));
    // zero-fitness slots ahead of the slice
    offer(breed_req(0, 0, 65535, 0));
    offer(breed_req(30000, 60000, 20000, 50000));
    settle();

    // Random phases, each under its own register settings
    for (phase = 0; phase < PHASES; phase++) begin
      write_pct = 40;
      case (phase)
        0: begin pop = 64;  rate = 65536;  items = 110; end
        1: begin pop = 1;   rate = 0;      items = 60;  end
        2: begin pop = 0;   rate = 131071; items = 60;  end
        3: begin
          pop = 127; rate = $urandom_range(0, 65536); items = 100; write_pct = 35;
        end
        4: begin pop = 5;   rate = 45875;  items = 100; end
        5: begin
          pop = $urandom_range(2, 63); rate = $urandom_range(0, 131071); items = 110;
        end
        default: begin pop = 64; rate = 32768; items = 110; write_pct = 35; end
      endcase
      apply_config(pop, rate);
      if (phase == PHASES - 1) quiet = 1'b1;
      // long output hold-off so the unit backs up into its input
      if (phase == 3) hold_asks++;
      repeat (items) offer(random_request(write_pct));
      settle();
    end
    repeat (300) @(posedge clk);

    $display("Covered %0d transactions, %0d breeds (%0d crossed over), %0d settings",
             sent, breeds_sent, crossings, PHASES + 1);
    $display("Checked %0d results, including a %0d-cycle output hold-off",
             results_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
